@@ src/dpas_pkg.sv @@
// ----------------------------------------------------------------------------
// dpas_pkg
// Shared types, opcodes and helpers for the data-processing ALU and shifter.
// ----------------------------------------------------------------------------
package dpas_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned AMT_W   = 8;
   localparam int unsigned FLAGS_W = 4;
   localparam int unsigned REG_W   = 4;

   // Flag positions inside an NZCV nibble
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   localparam logic [REG_W-1:0] REG_PC     = 4'hF;
   localparam logic [DATA_W-1:0] PC_AHEAD  = 32'd4;
   localparam logic [AMT_W-1:0] FULL_SHIFT = 8'd32;

   typedef enum logic [3:0] {
      OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
      OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
   } opcode_type;

   // Shift kind field, bits 6..5 of the instruction
   typedef enum logic [1:0] {
      KIND_LSL, KIND_LSR, KIND_ASR, KIND_ROR
   } shift_kind_type;

   typedef enum logic [2:0] {
      SH_PASS, SH_LSL, SH_LSR, SH_ASR, SH_ROR, SH_RRX
   } shift_op_type;

   typedef struct packed {
      opcode_type          opcode;
      logic                s_bit;
      logic [REG_W-1:0]    rd;
      logic [FLAGS_W-1:0]  flags;
   } ctrl_type;

   typedef struct packed {
      shift_op_type        op;
      logic [AMT_W-1:0]    amt;
      logic [DATA_W-1:0]   src;
   } shift_req_type;

   function automatic shift_op_type kind_to_op(input shift_kind_type kind);
      shift_op_type op;
      case (kind)
         KIND_LSL: op = SH_LSL;
         KIND_LSR: op = SH_LSR;
         KIND_ASR: op = SH_ASR;
         KIND_ROR: op = SH_ROR;
         default:  op = SH_PASS;
      endcase
      return op;
   endfunction

   function automatic logic is_compare(input opcode_type opcode);
      return (opcode == OP_TST) || (opcode == OP_TEQ) ||
             (opcode == OP_CMP) || (opcode == OP_CMN);
   endfunction

endpackage

@@ src/dpas_decode.sv @@
// ----------------------------------------------------------------------------
// dpas_decode
// First stage: field decode, PC read-ahead and shifter operand setup.
// ----------------------------------------------------------------------------
module dpas_decode import dpas_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DATA_W-1:0]   instruction,
   input  logic [DATA_W-1:0]   rn_value,
   input  logic [DATA_W-1:0]   rm_value,
   input  logic [AMT_W-1:0]    rs_low_byte,
   input  logic [FLAGS_W-1:0]  flags_in,
   output logic                out_valid,
   output ctrl_type            out_ctrl,
   output logic [DATA_W-1:0]   out_rn,
   output shift_req_type       out_shift
);

   logic                valid_ff;
   ctrl_type            ctrl_ff, ctrl_in;
   logic [DATA_W-1:0]   rn_ff, rn_in;
   shift_req_type       shift_ff, shift_in;

   logic                reg_shift;
   logic [4:0]          imm_amt;
   shift_kind_type      kind;

   always_comb begin
      reg_shift = !instruction[25] && instruction[4];
      imm_amt   = instruction[11:7];
      kind      = shift_kind_type'(instruction[6:5]);

      ctrl_in.opcode = opcode_type'(instruction[24:21]);
      ctrl_in.s_bit  = instruction[20];
      ctrl_in.rd     = instruction[15:12];
      ctrl_in.flags  = flags_in;

      // a register-specified shift sees the PC one word further on
      rn_in = (reg_shift && instruction[19:16] == REG_PC) ? rn_value + PC_AHEAD : rn_value;

      shift_in.src = rm_value;
      shift_in.amt = '0;
      shift_in.op  = SH_PASS;
      if (instruction[25]) begin
         shift_in.src = {{(DATA_W-8){1'b0}}, instruction[7:0]};
         shift_in.amt = {3'b000, instruction[11:8], 1'b0};
         shift_in.op  = (instruction[11:8] == 4'h0) ? SH_PASS : SH_ROR;
      end else if (instruction[4]) begin
         if (instruction[3:0] == REG_PC) begin
            shift_in.src = rm_value + PC_AHEAD;
         end
         shift_in.amt = rs_low_byte;
         shift_in.op  = (rs_low_byte == '0) ? SH_PASS : kind_to_op(kind);
      end else if (imm_amt == 5'd0) begin
         // zero immediate amount: LSL passes, LSR/ASR mean 32, ROR means RRX
         case (kind)
            KIND_LSL: shift_in.op = SH_PASS;
            KIND_LSR: begin
               shift_in.op  = SH_LSR;
               shift_in.amt = FULL_SHIFT;
            end
            KIND_ASR: begin
               shift_in.op  = SH_ASR;
               shift_in.amt = FULL_SHIFT;
            end
            KIND_ROR: shift_in.op = SH_RRX;
            default:  shift_in.op = SH_PASS;
         endcase
      end else begin
         shift_in.amt = {3'b000, imm_amt};
         shift_in.op  = kind_to_op(kind);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff  <= ctrl_in;
      rn_ff    <= rn_in;
      shift_ff <= shift_in;
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_rn    = rn_ff;
   assign out_shift = shift_ff;

endmodule

@@ src/dpas_shift.sv @@
// ----------------------------------------------------------------------------
// dpas_shift
// Second stage: barrel shifter producing operand 2 and the shifter carry.
// ----------------------------------------------------------------------------
module dpas_shift import dpas_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ctrl_type            in_ctrl,
   input  logic [DATA_W-1:0]   in_rn,
   input  shift_req_type       in_shift,
   output logic                out_valid,
   output ctrl_type            out_ctrl,
   output logic [DATA_W-1:0]   out_rn,
   output logic [DATA_W-1:0]   out_op2,
   output logic                out_carry
);

   logic                valid_ff;
   ctrl_type            ctrl_ff;
   logic [DATA_W-1:0]   rn_ff;
   logic [DATA_W-1:0]   op2_ff, op2_in;
   logic                carry_ff, carry_in;

   logic                cin;
   logic [4:0]          amt5;
   logic                amt_small;
   logic                amt_full;
   logic [DATA_W:0]     wide;
   logic [2*DATA_W-1:0] rot;
   logic [DATA_W-1:0]   src;

   always_comb begin
      src       = in_shift.src;
      cin       = in_ctrl.flags[FLAG_C];
      amt5      = in_shift.amt[4:0];
      amt_small = (in_shift.amt[AMT_W-1:5] == '0);
      amt_full  = (in_shift.amt == FULL_SHIFT);
      wide      = '0;
      rot       = {src, src} >> amt5;
      op2_in    = src;
      carry_in  = cin;
      case (in_shift.op)
         SH_PASS: begin
            op2_in   = src;
            carry_in = cin;
         end
         SH_LSL: begin
            wide = {1'b0, src} << amt5;
            if (amt_small) begin
               op2_in   = wide[DATA_W-1:0];
               carry_in = wide[DATA_W];
            end else begin
               op2_in   = '0;
               carry_in = amt_full & src[0];
            end
         end
         SH_LSR: begin
            wide = {src, 1'b0} >> amt5;
            if (amt_small) begin
               op2_in   = wide[DATA_W:1];
               carry_in = wide[0];
            end else begin
               op2_in   = '0;
               carry_in = amt_full & src[DATA_W-1];
            end
         end
         SH_ASR: begin
            wide = $unsigned($signed({src, 1'b0}) >>> amt5);
            if (amt_small) begin
               op2_in   = wide[DATA_W:1];
               carry_in = wide[0];
            end else begin
               op2_in   = {DATA_W{src[DATA_W-1]}};
               carry_in = src[DATA_W-1];
            end
         end
         SH_ROR: begin
            // carry is the bit rotated into the top, also for multiples of 32
            op2_in   = rot[DATA_W-1:0];
            carry_in = rot[DATA_W-1];
         end
         SH_RRX: begin
            op2_in   = {cin, src[DATA_W-1:1]};
            carry_in = src[0];
         end
         default: begin
            op2_in   = src;
            carry_in = cin;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff  <= in_ctrl;
      rn_ff    <= in_rn;
      op2_ff   <= op2_in;
      carry_ff <= carry_in;
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_rn    = rn_ff;
   assign out_op2   = op2_ff;
   assign out_carry = carry_ff;

endmodule

@@ src/dpas_alu.sv @@
// ----------------------------------------------------------------------------
// dpas_alu
// Third stage: 33-bit adder and logic unit with carry and overflow.
// ----------------------------------------------------------------------------
module dpas_alu import dpas_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ctrl_type            in_ctrl,
   input  logic [DATA_W-1:0]   in_rn,
   input  logic [DATA_W-1:0]   in_op2,
   input  logic                in_shift_carry,
   output logic                out_valid,
   output ctrl_type            out_ctrl,
   output logic [DATA_W-1:0]   out_result,
   output logic                out_carry,
   output logic                out_overflow
);

   logic                valid_ff;
   ctrl_type            ctrl_ff;
   logic [DATA_W-1:0]   result_ff, result_in;
   logic                carry_ff, carry_in;
   logic                overflow_ff, overflow_in;

   logic [DATA_W-1:0]   add_a;
   logic [DATA_W-1:0]   add_b;
   logic                add_ci;
   logic                arith;
   logic [DATA_W-1:0]   logic_r;
   logic [DATA_W:0]     sum;
   logic                cin;

   always_comb begin
      cin     = in_ctrl.flags[FLAG_C];
      add_a   = in_rn;
      add_b   = in_op2;
      add_ci  = 1'b0;
      arith   = 1'b0;
      logic_r = in_op2;
      case (in_ctrl.opcode)
         OP_AND, OP_TST: logic_r = in_rn & in_op2;
         OP_EOR, OP_TEQ: logic_r = in_rn ^ in_op2;
         OP_SUB, OP_CMP: begin
            add_b  = ~in_op2;
            add_ci = 1'b1;
            arith  = 1'b1;
         end
         OP_RSB: begin
            add_a  = in_op2;
            add_b  = ~in_rn;
            add_ci = 1'b1;
            arith  = 1'b1;
         end
         OP_ADD, OP_CMN: arith = 1'b1;
         OP_ADC: begin
            add_ci = cin;
            arith  = 1'b1;
         end
         OP_SBC: begin
            add_b  = ~in_op2;
            add_ci = cin;
            arith  = 1'b1;
         end
         OP_RSC: begin
            add_a  = in_op2;
            add_b  = ~in_rn;
            add_ci = cin;
            arith  = 1'b1;
         end
         OP_ORR: logic_r = in_rn | in_op2;
         OP_MOV: logic_r = in_op2;
         OP_BIC: logic_r = in_rn & ~in_op2;
         OP_MVN: logic_r = ~in_op2;
         default: logic_r = in_op2;
      endcase

      sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_ci};

      if (arith) begin
         result_in   = sum[DATA_W-1:0];
         carry_in    = sum[DATA_W];
         overflow_in = ~(add_a[DATA_W-1] ^ add_b[DATA_W-1]) &
                       (add_a[DATA_W-1] ^ sum[DATA_W-1]);
      end else begin
         // logical ops: carry from the shifter, V held
         result_in   = logic_r;
         carry_in    = in_shift_carry;
         overflow_in = in_ctrl.flags[FLAG_V];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff     <= in_ctrl;
      result_ff   <= result_in;
      carry_ff    <= carry_in;
      overflow_ff <= overflow_in;
   end

   assign out_valid    = valid_ff;
   assign out_ctrl     = ctrl_ff;
   assign out_result   = result_ff;
   assign out_carry    = carry_ff;
   assign out_overflow = overflow_ff;

endmodule

@@ src/data_processing_alu_shifter_unit.sv @@
// Each request passes through the decode, shifter, ALU and flag/output
// registers in order; rsp_valid is driven from the last of them.
// Throughput: one request per cycle while reset is low; decode, shifter, ALU
// and flag/output registers form four stages with no feedback between requests.
// busy is high only while reset is asserted; the result side never stalls.
// Reset (synchronous, active high) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// data_processing_alu_shifter_unit
// Data-processing execute unit: barrel shifter, ALU and NZCV flag update.
// ----------------------------------------------------------------------------
module data_processing_alu_shifter_unit import dpas_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [DATA_W-1:0]   req_instruction,
   input  logic [DATA_W-1:0]   req_rn_value,
   input  logic [DATA_W-1:0]   req_rm_value,
   input  logic [AMT_W-1:0]    req_rs_low_byte,
   input  logic [FLAGS_W-1:0]  req_flags_in,
   output logic                rsp_valid,
   output logic [DATA_W-1:0]   rsp_result,
   output logic                rsp_write_dest,
   output logic [REG_W-1:0]    rsp_dest_index,
   output logic [FLAGS_W-1:0]  rsp_flags_out,
   output logic                rsp_restore_spsr
);

   logic                s1_valid;
   ctrl_type            s1_ctrl;
   logic [DATA_W-1:0]   s1_rn;
   shift_req_type       s1_shift;

   logic                s2_valid;
   ctrl_type            s2_ctrl;
   logic [DATA_W-1:0]   s2_rn;
   logic [DATA_W-1:0]   s2_op2;
   logic                s2_carry;

   logic                s3_valid;
   ctrl_type            s3_ctrl;
   logic [DATA_W-1:0]   s3_result;
   logic                s3_carry;
   logic                s3_overflow;

   logic                valid_ff;
   logic [DATA_W-1:0]   result_ff, result_in;
   logic                write_ff, write_in;
   logic [REG_W-1:0]    dest_ff;
   logic [FLAGS_W-1:0]  flags_ff, flags_in;
   logic                restore_ff, restore_in;

   logic                accept;
   logic                set_flags;

   assign busy   = reset;
   assign accept = start && !busy;

   dpas_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .instruction (req_instruction),
      .rn_value    (req_rn_value),
      .rm_value    (req_rm_value),
      .rs_low_byte (req_rs_low_byte),
      .flags_in    (req_flags_in),
      .out_valid   (s1_valid),
      .out_ctrl    (s1_ctrl),
      .out_rn      (s1_rn),
      .out_shift   (s1_shift)
   );

   dpas_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ctrl   (s1_ctrl),
      .in_rn     (s1_rn),
      .in_shift  (s1_shift),
      .out_valid (s2_valid),
      .out_ctrl  (s2_ctrl),
      .out_rn    (s2_rn),
      .out_op2   (s2_op2),
      .out_carry (s2_carry)
   );

   dpas_alu u_alu (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid),
      .in_ctrl        (s2_ctrl),
      .in_rn          (s2_rn),
      .in_op2         (s2_op2),
      .in_shift_carry (s2_carry),
      .out_valid      (s3_valid),
      .out_ctrl       (s3_ctrl),
      .out_result     (s3_result),
      .out_carry      (s3_carry),
      .out_overflow   (s3_overflow)
   );

   always_comb begin
      write_in   = !is_compare(s3_ctrl.opcode);
      restore_in = write_in && s3_ctrl.s_bit && (s3_ctrl.rd == REG_PC);
      // compares always set flags; an SPSR restore leaves them alone
      set_flags  = !write_in || (s3_ctrl.s_bit && !restore_in);
      result_in  = write_in ? s3_result : '0;
      flags_in   = s3_ctrl.flags;
      if (set_flags) begin
         flags_in[FLAG_N] = s3_result[DATA_W-1];
         flags_in[FLAG_Z] = (s3_result == '0);
         flags_in[FLAG_C] = s3_carry;
         flags_in[FLAG_V] = s3_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff  <= result_in;
      write_ff   <= write_in;
      dest_ff    <= s3_ctrl.rd;
      flags_ff   <= flags_in;
      restore_ff <= restore_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result       = result_ff;
   assign rsp_write_dest   = write_ff;
   assign rsp_dest_index   = dest_ff;
   assign rsp_flags_out    = flags_ff;
   assign rsp_restore_spsr = restore_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("request did not produce a result four cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##4 !rsp_valid)
      else $error("result produced without a matching request");

   a_compare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_dest |-> rsp_result == '0)
      else $error("compare returned a nonzero result");

   a_restore_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restore_spsr |-> rsp_write_dest && rsp_dest_index == REG_PC)
      else $error("SPSR restore without a PC write");

endmodule
